>>> design/sws_pkg.sv
// shared types, codes and constants of the sliding window sender
`timescale 1ns / 1ps
`default_nettype none
package sws_pkg;

   localparam int SEQ_BITS     = 3;
   localparam int SEQ_SPACE    = 1 << SEQ_BITS;
   localparam int PAYLOAD_BITS = 32;
   localparam int WIN_BITS     = 3;
   localparam int THR_BITS     = 2;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 48;

   typedef logic [SEQ_BITS-1:0]     seq_type;
   typedef logic [PAYLOAD_BITS-1:0] payload_type;

   // event kinds
   typedef enum logic [1:0] {
      KIND_SEND   = 2'd0,
      KIND_ACK    = 2'd1,
      KIND_EXPIRE = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   // timer commands
   typedef enum logic [1:0] {
      TIMER_IDLE    = 2'd0,
      TIMER_START   = 2'd1,
      TIMER_STOP    = 2'd2,
      TIMER_RESTART = 2'd3
   } timer_type;

   // configuration register indexes
   typedef enum logic {
      CSR_WINDOW_SIZE = 1'b0,
      CSR_DUP_THRESH  = 1'b1
   } csr_index_type;

   localparam logic [1:0]    DUP_RESET  = 2'd1;
   localparam logic [2:0]    WIN_RESET  = 3'd3;
   localparam logic [1:0]    THR_RESET  = 2'd3;
   localparam seq_type       SEQ_RESET  = seq_type'(1);

   typedef struct packed {
      seq_type       expired_seq;
      logic          ack_valid_check;
      seq_type       ack_number;
      payload_type   payload;
      kind_type      kind;
   } item_type;

   typedef struct packed {
      seq_type       timer_seq;
      timer_type     timer_action;
      payload_type   packet_data;
      seq_type       packet_seq;
      logic          packet_out;
      logic          window_full;
      logic          accepted;
   } result_type;

endpackage
`default_nettype wire

>>> design/sws_engine.sv
// window state, packet store and per-event decision logic
`timescale 1ns / 1ps
`default_nettype none
module sws_engine (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           csr_we,
   input  wire  sws_pkg::csr_index_type  csr_index,
   input  wire  [sws_pkg::WIN_BITS-1:0]  csr_wdata,
   input  wire                           advance,
   input  wire  sws_pkg::item_type       item,
   output sws_pkg::result_type           result
);
   import sws_pkg::*;

   logic [WIN_BITS-1:0] win_size_ff;
   logic [THR_BITS-1:0] dup_thr_ff;
   seq_type             base_ff, base_in;
   seq_type             next_seq_ff, next_seq_in;
   logic [1:0]          dup_count_ff, dup_count_in;
   payload_type         store_ff [SEQ_SPACE];

   seq_type     outstanding, new_outstanding, ack_offset, prev_seq, read_seq;
   logic [1:0]  dup_inc;
   logic        full_now, store_we;
   payload_type read_data;

   assign outstanding = next_seq_ff - base_ff;
   assign full_now    = outstanding >= win_size_ff;
   assign ack_offset  = item.ack_number - base_ff;
   assign prev_seq    = base_ff - seq_type'(1);
   assign dup_inc     = dup_count_ff + 2'd1;
   assign read_seq    = (item.kind == KIND_EXPIRE) ? item.expired_seq : base_ff;
   assign read_data   = store_ff[read_seq];

   always_comb begin
      base_in      = base_ff;
      next_seq_in  = next_seq_ff;
      dup_count_in = dup_count_ff;
      store_we     = 1'b0;
      result       = '0;
      case (item.kind)
         KIND_SEND: begin
            if (!full_now) begin
               store_we           = 1'b1;
               result.accepted    = 1'b1;
               result.packet_out  = 1'b1;
               result.packet_seq  = next_seq_ff;
               result.packet_data = item.payload;
               if (base_ff == next_seq_ff) begin
                  result.timer_action = TIMER_START;
                  result.timer_seq    = base_ff;
               end
               next_seq_in = next_seq_ff + seq_type'(1);
            end
         end
         KIND_ACK: begin
            if (item.ack_valid_check) begin
               if (ack_offset < outstanding) begin
                  base_in      = item.ack_number + seq_type'(1);
                  dup_count_in = DUP_RESET;
                  if (base_in == next_seq_ff) begin
                     result.timer_action = TIMER_STOP;
                     result.timer_seq    = base_ff;
                  end else begin
                     result.timer_action = TIMER_RESTART;
                     result.timer_seq    = base_in;
                  end
               end else if (item.ack_number == prev_seq) begin
                  dup_count_in = dup_inc;
                  if (dup_inc == dup_thr_ff) begin
                     dup_count_in = 2'd0;
                     if (outstanding != '0) begin
                        result.packet_out  = 1'b1;
                        result.packet_seq  = base_ff;
                        result.packet_data = read_data;
                     end
                  end
               end
            end
         end
         KIND_EXPIRE: begin
            result.packet_out   = 1'b1;
            result.packet_seq   = item.expired_seq;
            result.packet_data  = read_data;
            result.timer_action = TIMER_RESTART;
            result.timer_seq    = item.expired_seq;
         end
         default: begin
         end
      endcase
      new_outstanding    = next_seq_in - base_in;
      result.window_full = new_outstanding >= win_size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff  <= WIN_RESET;
         dup_thr_ff   <= THR_RESET;
         base_ff      <= SEQ_RESET;
         next_seq_ff  <= SEQ_RESET;
         dup_count_ff <= DUP_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_WINDOW_SIZE: win_size_ff <= csr_wdata;
               CSR_DUP_THRESH:  dup_thr_ff  <= csr_wdata[THR_BITS-1:0];
               default: begin
               end
            endcase
         end
         if (advance) begin
            base_ff      <= base_in;
            next_seq_ff  <= next_seq_in;
            dup_count_ff <= dup_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && store_we) begin
         store_ff[next_seq_ff] <= item.payload;
      end
   end

   a_send_advances: assert property (@(posedge clock) disable iff (reset)
      advance && result.accepted |=> next_seq_ff == seq_type'($past(next_seq_ff) + 1'b1))
      else $error("accepted send did not advance the sequence number");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(base_ff) && $stable(next_seq_ff) && $stable(dup_count_ff))
      else $error("window state changed without an event");

   a_stop_empties: assert property (@(posedge clock) disable iff (reset)
      advance && result.timer_action == TIMER_STOP |=> base_ff == next_seq_ff)
      else $error("timer stopped while packets remain outstanding");

   a_full_refuses: assert property (@(posedge clock) disable iff (reset)
      advance && item.kind == KIND_SEND && full_now |-> !result.accepted && !result.packet_out)
      else $error("send taken while the window was full");

endmodule
`default_nettype wire

>>> design/sliding_window_sender.sv
// top level of the sliding window arq sender with fast retransmit
//
// usage
//   req_ channel carries one event per transaction: tuser is the kind
//   (send, acknowledgement, timer expiry), tdata the payload, the ack
//   number, its checksum flag and the expired timer tag
//   rsp_ channel returns exactly one result per event, in order: accepted,
//   window full, packet emit with sequence number and data, timer command
//   csr_ port writes window size (index 0) and duplicate ack threshold
//   (index 1), only while no event is in flight
// path: an accepted event waits in the input register, is decided by the engine
//   and its result is registered in the result slot
// throughput: one event per cycle unless the result is held, set by the single
//   decision stage that reads and updates base, next sequence number and duplicate count
// reset: base and next sequence number go to 1, duplicate count to 1,
//   window size and threshold to 3; the packet store is not cleared
// stall: a held result keeps the decision stage waiting; the input
//   register still takes one more event before req_tready falls
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_sender (
   input  wire                                  clock,
   input  wire                                  reset,
   // csr write port
   input  wire                                  csr_we,
   input  wire  sws_pkg::csr_index_type         csr_index,
   input  wire  [sws_pkg::WIN_BITS-1:0]         csr_wdata,
   // event channel
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // payload[31:0], ack_number[34:32], ack_valid_check[35], expired_seq[38:36], pad[39]
   input  wire  [sws_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // kind[1:0]
   input  wire  [1:0]                           req_tuser,
   // result channel
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // accepted[0], window_full[1], packet_out[2], packet_seq[5:3],
   // packet_data[37:6], timer_action[39:38], timer_seq[42:40], pad[47:43]
   output logic [sws_pkg::RSP_DATA_BITS-1:0]    rsp_tdata
);
   import sws_pkg::*;

   localparam int ITEM_DATA_BITS = $bits(item_type) - 2;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff, in_item_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type result;
   logic       advance, req_take;

   // decide when the input register holds an event and the result slot is free or being taken
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // unpack the event from tdata and tuser
   always_comb begin
      in_item_in      = in_item_ff;
      in_valid_in     = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = {req_tdata[ITEM_DATA_BITS-1:0], kind_type'(req_tuser)};
      end
   end

   // result slot: load on a decision, empty when taken downstream
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end
   end

   sws_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (advance),
      .item      (in_item_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers without reset
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - $bits(result_type)){1'b0}}, out_ff};

endmodule
`default_nettype wire

>>> bench/tb_sliding_window_sender.sv
// self-checking testbench of the sliding window arq sender
`timescale 1ns / 1ps
module tb_sliding_window_sender;
   import sws_pkg::*;

   localparam int PHASES          = 16;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int HOLD_PHASE      = 5;
   // receiver hold-off long enough to fill the two-stage pipe and stall req_
   localparam int HOLD_CYCLES     = 80;
   // slowest legal quiet stretch is the hold-off plus a long gap and a csr
   // pause, so a quiet stretch that reaches IDLE_LIMIT means a hang
   localparam int IDLE_LIMIT      = 1000;
   // window sizes per random phase, both extremes included
   localparam logic [2:0] WIN_PLAN [PHASES] =
      '{3'd7, 3'd1, 3'd0, 3'd5, 3'd3, 3'd7, 3'd2, 3'd6,
        3'd4, 3'd1, 3'd7, 3'd3, 3'd0, 3'd6, 3'd2, 3'd5};

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_we = 1'b0;
   csr_index_type            csr_index = CSR_WINDOW_SIZE;
   logic [WIN_BITS-1:0]      csr_wdata = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [1:0]               req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   sliding_window_sender u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // arq sender state as the testbench sees it
   // ---------------------------------------------------------------------
   seq_type          win_base   = SEQ_RESET;
   seq_type          next_no    = SEQ_RESET;
   logic [1:0]       dup_cnt    = DUP_RESET;
   logic [2:0]       cfg_window = WIN_RESET;
   logic [1:0]       cfg_thresh = THR_RESET;
   payload_type      slot_data [SEQ_SPACE];
   // slots that hold a payload; resends are only ever aimed at these
   logic [SEQ_SPACE-1:0] slot_written = '0;

   result_type       awaited [$];
   int               fails = 0;
   int               idle_cycles = 0;
   bit               hold_off_req = 1'b0;
   bit               hold_active = 1'b0;

   typedef struct {
      bit            is_csr;
      csr_index_type idx;
      logic [2:0]    val;
      item_type      it;
      bit            typed;
      result_type    want;
   } step_row;

   step_row dir_tab [$];

   function automatic seq_type in_flight();
      return seq_type'(next_no - win_base);
   endfunction

   // a 3-bit window never exceeds SEQ_SPACE-1, so no clamp is needed;
   // window zero makes this always true
   function automatic logic window_full_now();
      return in_flight() >= cfg_window;
   endfunction

   // one event through the sender, returns its result and moves the state
   function automatic result_type arq_predict(item_type it);
      result_type r;
      seq_type    old_base;
      r = '0;
      case (it.kind)
         KIND_SEND: begin
            if (!window_full_now()) begin
               r.accepted     = 1'b1;
               slot_data[next_no]    = it.payload;
               slot_written[next_no] = 1'b1;
               r.packet_out   = 1'b1;
               r.packet_seq   = next_no;
               r.packet_data  = it.payload;
               // first packet into an empty window starts the timer
               if (win_base == next_no) begin
                  r.timer_action = TIMER_START;
                  r.timer_seq    = win_base;
               end
               next_no = next_no + 1'b1;
            end
         end
         KIND_ACK: begin
            if (it.ack_valid_check) begin
               if (seq_type'(it.ack_number - win_base) < in_flight()) begin
                  // cumulative ack slides the base past the acked number
                  old_base = win_base;
                  win_base = it.ack_number + 1'b1;
                  dup_cnt  = DUP_RESET;
                  if (win_base == next_no) begin
                     r.timer_action = TIMER_STOP;
                     r.timer_seq    = old_base;
                  end else begin
                     r.timer_action = TIMER_RESTART;
                     r.timer_seq    = win_base;
                  end
               end else if (it.ack_number == seq_type'(win_base - 1'b1)) begin
                  // duplicate ack, count wraps modulo four
                  dup_cnt = dup_cnt + 1'b1;
                  if (dup_cnt == cfg_thresh) begin
                     if (in_flight() != 0) begin
                        r.packet_out  = 1'b1;
                        r.packet_seq  = win_base;
                        r.packet_data = slot_data[win_base];
                     end
                     dup_cnt = '0;
                  end
               end
            end
         end
         KIND_EXPIRE: begin
            // resend the tagged slot, outstanding or not
            r.packet_out   = 1'b1;
            r.packet_seq   = it.expired_seq;
            r.packet_data  = slot_data[it.expired_seq];
            r.timer_action = TIMER_RESTART;
            r.timer_seq    = it.expired_seq;
         end
         default: ;
      endcase
      r.window_full = window_full_now();
      return r;
   endfunction

   // random event, mostly well-formed traffic around the current window
   function automatic item_type next_event();
      item_type    it;
      int unsigned pick;
      seq_type     span;
      seq_type     tag;
      it.kind            = KIND_SEND;
      it.payload         = $urandom();
      it.ack_number      = seq_type'($urandom_range(0, 7));
      it.ack_valid_check = 1'($urandom_range(0, 1));
      it.expired_seq     = seq_type'($urandom_range(0, 7));
      span = in_flight();
      pick = $urandom_range(0, 99);
      if (pick >= 42) begin
         if (pick < 70 && span != 0) begin
            it.kind            = KIND_ACK;
            it.ack_valid_check = 1'b1;
            it.ack_number      = win_base + seq_type'($urandom_range(0, span - 1));
         end else if (pick < 80) begin
            it.kind            = KIND_ACK;
            it.ack_valid_check = 1'b1;
            it.ack_number      = win_base - 1'b1;
         end else if (pick < 88 && slot_written != '0) begin
            it.kind = KIND_EXPIRE;
            if (span != 0 && $urandom_range(0, 1) == 1) begin
               tag = win_base + seq_type'($urandom_range(0, span - 1));
            end else begin
               tag = seq_type'($urandom_range(0, 7));
               while (!slot_written[tag]) tag = seq_type'($urandom_range(0, 7));
            end
            it.expired_seq = tag;
         end else if (pick < 94) begin
            // stray ack, random number and checksum flag
            it.kind = KIND_ACK;
         end else begin
            it.kind = KIND_NONE;
         end
      end
      return it;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic step_row ev(kind_type k, payload_type p, seq_type ack, logic chk,
                                  seq_type tag);
      step_row s;
      s = '{is_csr: 1'b0, idx: CSR_WINDOW_SIZE, val: '0, it: '0, typed: 1'b0, want: '0};
      s.it.kind            = k;
      s.it.payload         = p;
      s.it.ack_number      = ack;
      s.it.ack_valid_check = chk;
      s.it.expired_seq     = tag;
      return s;
   endfunction

   function automatic step_row wr(csr_index_type idx, logic [2:0] val);
      step_row s;
      s = '{is_csr: 1'b1, idx: idx, val: val, it: '0, typed: 1'b0, want: '0};
      return s;
   endfunction

   function automatic step_row chk(step_row s, result_type want);
      s.typed = 1'b1;
      s.want  = want;
      return s;
   endfunction

   function automatic result_type res(logic acc, logic full, logic pkt, seq_type sq,
                                      payload_type d, timer_type ta, seq_type ts);
      result_type r;
      r.accepted     = acc;
      r.window_full  = full;
      r.packet_out   = pkt;
      r.packet_seq   = sq;
      r.packet_data  = d;
      r.timer_action = ta;
      r.timer_seq    = ts;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------
   task automatic pause(int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // offer one event, hold it until the transaction, then record what to expect
   task automatic offer(item_type it, bit typed, result_type want);
      result_type model;
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {1'b0, it.expired_seq, it.ack_valid_check, it.ack_number, it.payload};
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
      model = arq_predict(it);
      awaited.push_back(typed ? want : model);
   endtask

   // csr writes only with the pipe empty: drain, let the last result settle
   task automatic write_csr(csr_index_type idx, logic [2:0] val);
      req_tvalid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_WINDOW_SIZE) cfg_window = val;
      else cfg_thresh = val[1:0];
   endtask

   initial begin : stimulus
      bit steady;
      // directed walk from reset: window 3, threshold 3, base and next at 1
      dir_tab = '{
         // first send into the empty window starts the timer
         chk(ev(KIND_SEND, 32'h0000_0000, 3'd5, 1'b1, 3'd6),
             res(1, 0, 1, 3'd1, 32'h0000_0000, TIMER_START, 3'd1)),
         chk(ev(KIND_SEND, 32'hFFFF_FFFF, 3'd7, 1'b1, 3'd7),
             res(1, 0, 1, 3'd2, 32'hFFFF_FFFF, TIMER_IDLE, 3'd0)),
         // third packet fills the window
         chk(ev(KIND_SEND, 32'hA5A5_5A5A, 3'd0, 1'b0, 3'd0),
             res(1, 1, 1, 3'd3, 32'hA5A5_5A5A, TIMER_IDLE, 3'd0)),
         // send refused while full
         chk(ev(KIND_SEND, 32'h1234_5678, 3'd2, 1'b1, 3'd1),
             res(0, 1, 0, 3'd0, 32'h0, TIMER_IDLE, 3'd0)),
         // checksum failed, ack ignored
         chk(ev(KIND_ACK, 32'hFFFF_FFFF, 3'd1, 1'b0, 3'd7),
             res(0, 1, 0, 3'd0, 32'h0, TIMER_IDLE, 3'd0)),
         // duplicates of base-1 up to the threshold resend the base
         chk(ev(KIND_ACK, 32'h0, 3'd0, 1'b1, 3'd0),
             res(0, 1, 0, 3'd0, 32'h0, TIMER_IDLE, 3'd0)),
         chk(ev(KIND_ACK, 32'h0, 3'd0, 1'b1, 3'd0),
             res(0, 1, 1, 3'd1, 32'h0, TIMER_IDLE, 3'd0)),
         ev(KIND_ACK, 32'h5555_AAAA, 3'd0, 1'b1, 3'd5),
         // timer expiry resends the tagged packet
         chk(ev(KIND_EXPIRE, 32'h0, 3'd6, 1'b0, 3'd2),
             res(0, 1, 1, 3'd2, 32'hFFFF_FFFF, TIMER_RESTART, 3'd2)),
         // ack in window slides the base, timer restarts on it
         chk(ev(KIND_ACK, 32'h0, 3'd1, 1'b1, 3'd0),
             res(0, 0, 0, 3'd0, 32'h0, TIMER_RESTART, 3'd2)),
         // ack outside the window and not base-1
         chk(ev(KIND_ACK, 32'h0, 3'd7, 1'b1, 3'd0),
             res(0, 0, 0, 3'd0, 32'h0, TIMER_IDLE, 3'd0)),
         // unknown kind
         chk(ev(KIND_NONE, 32'hFFFF_FFFF, 3'd7, 1'b1, 3'd7),
             res(0, 0, 0, 3'd0, 32'h0, TIMER_IDLE, 3'd0)),
         // last outstanding packet acked, timer stops on the old base
         chk(ev(KIND_ACK, 32'h0, 3'd3, 1'b1, 3'd0),
             res(0, 0, 0, 3'd0, 32'h0, TIMER_STOP, 3'd2)),
         ev(KIND_ACK, 32'h0, 3'd3, 1'b1, 3'd0),
         // threshold reached with nothing outstanding, no resend
         chk(ev(KIND_ACK, 32'h0, 3'd3, 1'b1, 3'd0),
             res(0, 0, 0, 3'd0, 32'h0, TIMER_IDLE, 3'd0)),
         // expiry of a slot that is no longer outstanding
         chk(ev(KIND_EXPIRE, 32'h0, 3'd0, 1'b1, 3'd3),
             res(0, 0, 1, 3'd3, 32'hA5A5_5A5A, TIMER_RESTART, 3'd3)),
         // window zero refuses every send
         wr(CSR_WINDOW_SIZE, 3'd0),
         chk(ev(KIND_SEND, 32'h0000_0055, 3'd4, 1'b0, 3'd4),
             res(0, 1, 0, 3'd0, 32'h0, TIMER_IDLE, 3'd0)),
         wr(CSR_WINDOW_SIZE, 3'd7),
         chk(ev(KIND_SEND, 32'h0F0F_0F0F, 3'd4, 1'b0, 3'd4),
             res(1, 0, 1, 3'd4, 32'h0F0F_0F0F, TIMER_START, 3'd4)),
         // lower threshold, two duplicates resend the base
         wr(CSR_DUP_THRESH, 3'd2),
         ev(KIND_ACK, 32'h0, 3'd3, 1'b1, 3'd0),
         chk(ev(KIND_ACK, 32'h0, 3'd3, 1'b1, 3'd0),
             res(0, 0, 1, 3'd4, 32'h0F0F_0F0F, TIMER_IDLE, 3'd0))
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].is_csr) begin
            write_csr(dir_tab[i].idx, dir_tab[i].val);
         end else begin
            pause(gap_len());
            offer(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
         end
      end

      // random phases, each one starts from a drained pipe with new settings
      for (int p = 0; p < PHASES; p++) begin
         write_csr(CSR_WINDOW_SIZE, WIN_PLAN[p]);
         write_csr(CSR_DUP_THRESH, 3'(p % 4));
         steady = (p % 4 == 2) || (p == HOLD_PHASE);
         // receiver stalls for a long stretch while we keep pushing;
         // wait until the hold-off has begun so the phase starts inside it
         if (p == HOLD_PHASE) begin
            hold_off_req = 1'b1;
            wait (hold_active);
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pause(steady ? 0 : gap_len());
            offer(next_event(), 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fails == 0 && awaited.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // receiver side: random back-pressure, one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin : receiver
      int run;
      int gap;
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_active = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
            hold_active  = 1'b0;
         end else begin
            // occasional long stretch with no stalls
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
            rsp_tready <= 1'b1;
            repeat (run) @(posedge clock);
            gap = gap_len();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // result checking, field by field against the oldest expectation
   // ---------------------------------------------------------------------
   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin : result_check
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
         if (awaited.size() == 0) begin
            $display("%0t: unexpected transaction expected none got %h", $time, rsp_tdata);
            fails++;
         end else begin
            want = awaited.pop_front();
            check_field("accepted", 32'(want.accepted), 32'(got.accepted));
            check_field("window_full", 32'(want.window_full), 32'(got.window_full));
            check_field("packet_out", 32'(want.packet_out), 32'(got.packet_out));
            check_field("packet_seq", 32'(want.packet_seq), 32'(got.packet_seq));
            check_field("packet_data", want.packet_data, got.packet_data);
            check_field("timer_action", 32'(want.timer_action), 32'(got.timer_action));
            check_field("timer_seq", 32'(want.timer_seq), 32'(got.timer_seq));
         end
      end
   end

   // watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

endmodule
